// ===== design/strint_pkg.sv =====
// Shared types and character constants of the string-to-integer parser.
`default_nettype none

package strint_pkg;

  typedef struct packed {
    logic [7:0] ch;
    logic       first;
  } in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [15:0]        consumed;
    logic               digits_found;
    logic               overflow;
  } out_t;

  localparam logic [5:0] BASE_AUTO = 6'd0;
  localparam logic [5:0] BASE_OCT  = 6'd8;
  localparam logic [5:0] BASE_DEC  = 6'd10;
  localparam logic [5:0] BASE_HEX  = 6'd16;

  localparam logic [7:0] CH_TAB     = 8'd9;
  localparam logic [7:0] CH_CR      = 8'd13;
  localparam logic [7:0] CH_SPACE   = 8'd32;
  localparam logic [7:0] CH_PLUS    = 8'h2B;
  localparam logic [7:0] CH_MINUS   = 8'h2D;
  localparam logic [7:0] CH_ZERO    = 8'h30;
  localparam logic [7:0] CH_NINE    = 8'h39;
  localparam logic [7:0] CH_UPPER_A = 8'h41;
  localparam logic [7:0] CH_UPPER_X = 8'h58;
  localparam logic [7:0] CH_UPPER_Z = 8'h5A;
  localparam logic [7:0] CH_LOWER_A = 8'h61;
  localparam logic [7:0] CH_LOWER_X = 8'h78;
  localparam logic [7:0] CH_LOWER_Z = 8'h7A;

  // Letter offsets: 'A' - 10 and 'a' - 10
  localparam logic [7:0] UPPER_OFS = 8'd55;
  localparam logic [7:0] LOWER_OFS = 8'd87;

endpackage

`default_nettype wire

// ===== design/strint_digit.sv =====
// Digit decode and saturating multiply-add of the magnitude by the base.
`default_nettype none

module strint_digit #(
  parameter int VALUE_WIDTH = 64
) (
  input  wire logic [7:0]             ch_i,
  input  wire logic [5:0]             base_i,
  input  wire logic [VALUE_WIDTH-1:0] acc_i,
  input  wire logic                   neg_i,
  output      logic                   digit_ok_o,
  output      logic [VALUE_WIDTH-1:0] acc_o,
  output      logic                   ovf_o
);

  localparam int MW = VALUE_WIDTH + 7;

  logic [7:0]    raw;
  logic          is_char;
  logic [5:0]    digit;
  logic [MW-1:0] mac;
  logic [MW-1:0] lim;

  always_comb begin
    raw     = 8'd0;
    is_char = 1'b0;
    if (ch_i >= strint_pkg::CH_ZERO && ch_i <= strint_pkg::CH_NINE) begin
      raw     = ch_i - strint_pkg::CH_ZERO;
      is_char = 1'b1;
    end else if (ch_i >= strint_pkg::CH_UPPER_A && ch_i <= strint_pkg::CH_UPPER_Z) begin
      raw     = ch_i - strint_pkg::UPPER_OFS;
      is_char = 1'b1;
    end else if (ch_i >= strint_pkg::CH_LOWER_A && ch_i <= strint_pkg::CH_LOWER_Z) begin
      raw     = ch_i - strint_pkg::LOWER_OFS;
      is_char = 1'b1;
    end
    digit      = raw[5:0];
    digit_ok_o = is_char && (digit < base_i);
  end

  // acc * base + digit > lim is the same test as acc > (lim - digit) / base
  always_comb begin
    lim   = (MW'(1) << (VALUE_WIDTH - 1)) - (neg_i ? MW'(0) : MW'(1));
    mac   = MW'(acc_i) * MW'(base_i) + MW'(digit);
    ovf_o = mac > lim;
    acc_o = ovf_o ? lim[VALUE_WIDTH-1:0] : mac[VALUE_WIDTH-1:0];
  end

endmodule

`default_nettype wire

// ===== design/string_to_integer_parser.sv =====
// Top level of the string-to-integer parser: input stage, parse state and result stage.
`default_nettype none

// Parses a signed integer from a stream of characters, one character per transfer, in
// the radix held by the base register (0 selects detection from a 0x or 0 prefix). A
// transfer with first set starts a new string; the first character that is not part of
// the number produces one result, and characters after it are dropped until the next
// first. The block takes one character every cycle while no result waits for the
// receiver; a result is presented after the stopping character passes the input
// register and then the result register, which takes the signed magnitude and count.
// While a result waits for the receiver the parse state holds and the input register
// takes at most one more character, so input stalls until the result is taken.
// Write the base only while no string is being parsed.
module string_to_integer_parser #(
  parameter int VALUE_WIDTH = 64,
  parameter int COUNT_WIDTH = 16
) (
  input  wire logic              clk_i,
  input  wire logic              rst_ni,
  input  wire logic              in_valid_i,
  output      logic              in_ready_o,
  input  wire strint_pkg::in_t   in_data_i,
  output      logic              out_valid_o,
  input  wire logic              out_ready_i,
  output      strint_pkg::out_t  out_data_o,
  input  wire logic              cfg_valid_i,
  output      logic              cfg_ready_o,
  input  wire logic [5:0]        cfg_data_i
);

  typedef enum logic [2:0] {
    PH_IDLE,
    PH_WS,
    PH_PRE,
    PH_ZERO,
    PH_DIGITS
  } phase_e;

  localparam logic [63:0] VAL_MAX = (64'd1 << (VALUE_WIDTH - 1)) - 64'd1;
  localparam logic [63:0] VAL_MIN = ~VAL_MAX;

  strint_pkg::in_t  in_q;
  logic             in_valid_q;
  strint_pkg::out_t out_q, out_d;
  logic             out_valid_q;
  logic [5:0]       cfg_base_q;

  phase_e                 phase_q, phase_d;
  logic                   neg_q, neg_d;
  logic [VALUE_WIDTH-1:0] acc_q, acc_d;
  logic [5:0]             base_q, base_d;
  logic                   any_q, any_d;
  logic                   ovf_q, ovf_d;
  logic [COUNT_WIDTH-1:0] cnt_q, cnt_d;

  phase_e                 cur_phase;
  logic                   cur_neg, cur_any, cur_ovf;
  logic [VALUE_WIDTH-1:0] cur_acc;
  logic [5:0]             cur_base, base_use;
  logic [COUNT_WIDTH-1:0] cur_cnt, cnt_inc;
  logic                   any_use, take_digit, emit;
  logic                   is_ws, is_sign, pre_zero, is_x;
  logic                   advance;

  logic                   digit_ok, mac_ovf;
  logic [VALUE_WIDTH-1:0] mac_acc;
  logic [VALUE_WIDTH-1:0] signed_mag;
  logic [31:0]            cnt_ext;

  assign advance     = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o  = !in_valid_q || advance;
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;
  assign cfg_ready_o = 1'b1;

  strint_digit #(
    .VALUE_WIDTH(VALUE_WIDTH)
  ) u_digit (
    .ch_i       (in_q.ch),
    .base_i     (base_use),
    .acc_i      (cur_acc),
    .neg_i      (cur_neg),
    .digit_ok_o (digit_ok),
    .acc_o      (mac_acc),
    .ovf_o      (mac_ovf)
  );

  always_comb begin
    // a first character restarts the parse from a clean state
    cur_phase = in_q.first ? PH_WS : phase_q;
    cur_neg   = in_q.first ? 1'b0 : neg_q;
    cur_acc   = in_q.first ? '0 : acc_q;
    cur_base  = in_q.first ? cfg_base_q : base_q;
    cur_any   = in_q.first ? 1'b0 : any_q;
    cur_ovf   = in_q.first ? 1'b0 : ovf_q;
    cur_cnt   = in_q.first ? '0 : cnt_q;
    cnt_inc   = (cur_cnt == '1) ? cur_cnt : cur_cnt + COUNT_WIDTH'(1);

    is_ws    = (in_q.ch == strint_pkg::CH_SPACE) ||
               (in_q.ch >= strint_pkg::CH_TAB && in_q.ch <= strint_pkg::CH_CR);
    is_sign  = (in_q.ch == strint_pkg::CH_MINUS) || (in_q.ch == strint_pkg::CH_PLUS);
    pre_zero = ((cur_base == strint_pkg::BASE_AUTO) || (cur_base == strint_pkg::BASE_HEX)) &&
               (in_q.ch == strint_pkg::CH_ZERO);
    is_x     = (in_q.ch == strint_pkg::CH_LOWER_X) || (in_q.ch == strint_pkg::CH_UPPER_X);

    phase_d    = cur_phase;
    neg_d      = cur_neg;
    acc_d      = cur_acc;
    base_d     = cur_base;
    any_d      = cur_any;
    ovf_d      = cur_ovf;
    cnt_d      = cur_cnt;
    base_use   = cur_base;
    any_use    = cur_any;
    take_digit = 1'b0;
    emit       = 1'b0;

    unique case (cur_phase)
      PH_IDLE: begin
        phase_d = PH_IDLE;
      end
      PH_WS, PH_PRE: begin
        if (cur_phase == PH_WS && is_ws) begin
          cnt_d = cnt_inc;
        end else if (cur_phase == PH_WS && is_sign) begin
          neg_d   = (in_q.ch == strint_pkg::CH_MINUS);
          cnt_d   = cnt_inc;
          phase_d = PH_PRE;
        end else if (pre_zero) begin
          cnt_d   = cnt_inc;
          phase_d = PH_ZERO;
        end else begin
          base_use   = (cur_base == strint_pkg::BASE_AUTO) ? strint_pkg::BASE_DEC : cur_base;
          take_digit = 1'b1;
        end
      end
      PH_ZERO: begin
        if (is_x) begin
          base_d  = strint_pkg::BASE_HEX;
          cnt_d   = cnt_inc;
          phase_d = PH_DIGITS;
        end else begin
          // the leading zero counts as a digit
          base_use   = (cur_base == strint_pkg::BASE_AUTO) ? strint_pkg::BASE_OCT : cur_base;
          any_use    = 1'b1;
          take_digit = 1'b1;
        end
      end
      PH_DIGITS: begin
        take_digit = 1'b1;
      end
      default: begin
        phase_d = PH_IDLE;
      end
    endcase

    if (take_digit) begin
      base_d  = base_use;
      any_d   = any_use;
      phase_d = PH_DIGITS;
      if (!digit_ok) begin
        emit    = 1'b1;
        phase_d = PH_IDLE;
      end else begin
        cnt_d = cnt_inc;
        any_d = 1'b1;
        // hold the saturated value once overflow is seen
        if (!cur_ovf) begin
          acc_d = mac_acc;
          ovf_d = mac_ovf;
        end
      end
    end

    signed_mag = cur_neg ? (~cur_acc + VALUE_WIDTH'(1)) : cur_acc;
    cnt_ext    = 32'(cur_cnt);
    out_d.value        = 64'($signed(signed_mag));
    out_d.consumed     = !any_use ? 16'd0 :
                         (cnt_ext > 32'h0000_FFFF) ? 16'hFFFF : cnt_ext[15:0];
    out_d.digits_found = any_use;
    out_d.overflow     = cur_ovf;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
      cfg_base_q  <= strint_pkg::BASE_AUTO;
      phase_q     <= PH_IDLE;
      neg_q       <= 1'b0;
      acc_q       <= '0;
      base_q      <= strint_pkg::BASE_AUTO;
      any_q       <= 1'b0;
      ovf_q       <= 1'b0;
      cnt_q       <= '0;
    end else begin
      if (cfg_valid_i && cfg_ready_o) begin
        cfg_base_q <= cfg_data_i;
      end
      if (in_valid_i && in_ready_o) begin
        in_valid_q <= 1'b1;
      end else if (advance) begin
        in_valid_q <= 1'b0;
      end
      if (advance && emit) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (advance) begin
        phase_q <= phase_d;
        neg_q   <= neg_d;
        acc_q   <= acc_d;
        base_q  <= base_d;
        any_q   <= any_d;
        ovf_q   <= ovf_d;
        cnt_q   <= cnt_d;
      end
    end
  end

  // payload stages
  always_ff @(posedge clk_i) begin
    if (in_valid_i && in_ready_o) begin
      in_q <= in_data_i;
    end
    if (advance && emit) begin
      out_q <= out_d;
    end
  end

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.digits_found |->
      out_data_o.consumed == 16'd0 && out_data_o.value == 64'sd0 && !out_data_o.overflow)
    else $error("result without digits carries a value, count or overflow");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_data_o.overflow |->
      (out_data_o.value == VAL_MAX) || (out_data_o.value == VAL_MIN))
    else $error("overflowed result is not saturated");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    advance && emit |=> phase_q == PH_IDLE && out_valid_o)
    else $error("parse did not close after its result");

endmodule

`default_nettype wire

// ===== tb/tb.sv =====
// Testbench for string_to_integer_parser: directed strings, random strings against a predictor, then leading spaces.
`timescale 1ns / 100ps

module tb;

  localparam int SETTLE_CYCLES   = 8;
  localparam int HOLD_OFF_CYCLES = 400;
  localparam int STALL_LIMIT     = 2000;   // several times the longest planned hold-off
  localparam int ITEMS_PER_PHASE = 68;
  localparam int LEAD_SPACES     = 5;

  localparam logic [7:0]       CH_NUL   = 8'h00;
  localparam logic [63:0]      LIM_POS  = 64'h7FFF_FFFF_FFFF_FFFF;
  localparam logic [63:0]      LIM_NEG  = 64'h8000_0000_0000_0000;
  localparam logic [15:0]      CNT_MAX  = 16'hFFFF;
  localparam strint_pkg::out_t NO_RES   = '0;

  typedef enum logic [2:0] {
    SCAN_IDLE, SCAN_SPACE, SCAN_SIGN, SCAN_ZERO, SCAN_DIGITS
  } scan_e;

  typedef struct packed {
    logic [5:0]       base;
    logic [7:0]       ch;
    logic             first;
    logic             typed;
    strint_pkg::out_t res;
  } plan_row_t;

  logic             clk_i       = 1'b0;
  logic             rst_ni      = 1'b0;
  logic             in_valid_i  = 1'b0;
  logic             in_ready_o;
  strint_pkg::in_t  in_data_i   = '0;
  logic             out_valid_o;
  logic             out_ready_i = 1'b0;
  strint_pkg::out_t out_data_o;
  logic             cfg_valid_i = 1'b0;
  logic             cfg_ready_o;
  logic [5:0]       cfg_data_i  = '0;

  string_to_integer_parser dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o),
    .cfg_valid_i (cfg_valid_i),
    .cfg_ready_o (cfg_ready_o),
    .cfg_data_i  (cfg_data_i)
  );

  always begin
    #2 clk_i = 1'b1;
    #2 clk_i = 1'b0;
  end

  // Directed strings; results are typed in where they are obvious.
  plan_row_t plan [24] = '{
    '{strint_pkg::BASE_AUTO, "5",                    1'b0, 1'b0, NO_RES},  // no string yet
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_SPACE,   1'b1, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_MINUS,   1'b0, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_ZERO,    1'b0, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_LOWER_X, 1'b0, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, "f",                    1'b0, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, "F",                    1'b0, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, "g", 1'b0, 1'b1, '{-64'sd255, 16'd6, 1'b1, 1'b0}},
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_ZERO,    1'b1, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_UPPER_X, 1'b0, 1'b0, NO_RES},
    // bare hex prefix
    '{strint_pkg::BASE_AUTO, "z", 1'b0, 1'b1, '{64'sd0, 16'd0, 1'b0, 1'b0}},
    '{strint_pkg::BASE_AUTO, "9",                    1'b1, 1'b0, NO_RES},  // dropped by next first
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_ZERO,    1'b1, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, "1",                    1'b0, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, "7",                    1'b0, 1'b0, NO_RES},
    '{strint_pkg::BASE_AUTO, "8", 1'b0, 1'b1, '{64'sd15, 16'd3, 1'b1, 1'b0}},
    '{strint_pkg::BASE_AUTO, strint_pkg::CH_PLUS,    1'b1, 1'b0, NO_RES},
    // sign, no digit
    '{strint_pkg::BASE_AUTO, "q", 1'b0, 1'b1, '{64'sd0, 16'd0, 1'b0, 1'b0}},
    '{strint_pkg::BASE_AUTO, 8'hFF,                  1'b0, 1'b0, NO_RES},  // after the result
    '{6'd1,                  strint_pkg::CH_ZERO,    1'b1, 1'b0, NO_RES},
    '{6'd1,                  strint_pkg::CH_ZERO,    1'b0, 1'b0, NO_RES},
    '{6'd1,                  "1", 1'b0, 1'b1, '{64'sd0, 16'd2, 1'b1, 1'b0}},
    '{6'd63,                 strint_pkg::CH_UPPER_Z, 1'b1, 1'b0, NO_RES},
    '{6'd63,                 CH_NUL, 1'b0, 1'b1, '{64'sd35, 16'd1, 1'b1, 1'b0}}
  };

  strint_pkg::out_t results_due [$];
  int               mismatches   = 0;
  int               burst_left   = 0;
  bit               hold_off_req = 1'b0;
  int unsigned      idle_cycles  = 0;

  // Parser shadow state
  logic [5:0]  base_reg  = strint_pkg::BASE_AUTO;
  scan_e       scan      = SCAN_IDLE;
  logic        neg       = 1'b0;
  logic [63:0] mag       = '0;
  logic [5:0]  eff_base  = '0;
  logic        any_digit = 1'b0;
  logic        ovf       = 1'b0;
  logic [15:0] chars     = '0;

  function automatic int char_digit(logic [7:0] c);
    if (c >= strint_pkg::CH_ZERO && c <= strint_pkg::CH_NINE)
      return int'(c - strint_pkg::CH_ZERO);
    if (c >= strint_pkg::CH_UPPER_A && c <= strint_pkg::CH_UPPER_Z)
      return int'(c - strint_pkg::UPPER_OFS);
    if (c >= strint_pkg::CH_LOWER_A && c <= strint_pkg::CH_LOWER_Z)
      return int'(c - strint_pkg::LOWER_OFS);
    return -1;
  endfunction

  function automatic void count_char();
    if (chars != CNT_MAX) chars++;
  endfunction

  function automatic strint_pkg::out_t close_string();
    strint_pkg::out_t r;
    r.value        = neg ? 64'd0 - mag : mag;
    r.consumed     = any_digit ? chars : '0;
    r.digits_found = any_digit;
    r.overflow     = ovf;
    scan = SCAN_IDLE;
    return r;
  endfunction

  function automatic bit take_digit(logic [7:0] c, output strint_pkg::out_t r);
    int          dv;
    logic [63:0] d;
    logic [63:0] b;
    logic [63:0] lim;
    r  = NO_RES;
    dv = char_digit(c);
    if (dv < 0 || dv >= int'(eff_base)) begin
      r = close_string();
      return 1'b1;
    end
    d   = dv;
    b   = eff_base;
    lim = neg ? LIM_NEG : LIM_POS;
    count_char();
    any_digit = 1'b1;
    // Saturated magnitude holds; later digits only advance the count
    if (!ovf) begin
      if (mag > (lim - d) / b) begin
        ovf = 1'b1;
        mag = lim;
      end else begin
        mag = mag * b + d;
      end
    end
    return 1'b0;
  endfunction

  function automatic bit take_lead(logic [7:0] c, output strint_pkg::out_t r);
    r = NO_RES;
    if ((eff_base == strint_pkg::BASE_AUTO || eff_base == strint_pkg::BASE_HEX) &&
        c == strint_pkg::CH_ZERO) begin
      count_char();
      scan = SCAN_ZERO;
      return 1'b0;
    end
    if (eff_base == strint_pkg::BASE_AUTO) eff_base = strint_pkg::BASE_DEC;
    scan = SCAN_DIGITS;
    return take_digit(c, r);
  endfunction

  function automatic bit parse_char(strint_pkg::in_t item, output strint_pkg::out_t r);
    logic [7:0] c;
    c = item.ch;
    r = NO_RES;
    if (item.first) begin
      scan      = SCAN_SPACE;
      neg       = 1'b0;
      mag       = '0;
      eff_base  = base_reg;
      any_digit = 1'b0;
      ovf       = 1'b0;
      chars     = '0;
    end else if (scan == SCAN_IDLE) begin
      return 1'b0;
    end
    case (scan)
      SCAN_SPACE: begin
        if (c == strint_pkg::CH_SPACE ||
            (c >= strint_pkg::CH_TAB && c <= strint_pkg::CH_CR)) begin
          count_char();
          return 1'b0;
        end
        if (c == strint_pkg::CH_MINUS || c == strint_pkg::CH_PLUS) begin
          neg = (c == strint_pkg::CH_MINUS);
          count_char();
          scan = SCAN_SIGN;
          return 1'b0;
        end
        return take_lead(c, r);
      end
      SCAN_SIGN: return take_lead(c, r);
      SCAN_ZERO: begin
        if (c == strint_pkg::CH_LOWER_X || c == strint_pkg::CH_UPPER_X) begin
          eff_base = strint_pkg::BASE_HEX;
          count_char();
          scan = SCAN_DIGITS;
          return 1'b0;
        end
        // The leading zero turns out to be a digit
        if (eff_base == strint_pkg::BASE_AUTO) eff_base = strint_pkg::BASE_OCT;
        any_digit = 1'b1;
        scan = SCAN_DIGITS;
        return take_digit(c, r);
      end
      default: return take_digit(c, r);
    endcase
  endfunction

  // Offer one character, predict on its transfer, then maybe pause the sender.
  task automatic offer_char(input strint_pkg::in_t item, input bit typed,
                            input strint_pkg::out_t typed_res);
    strint_pkg::out_t r;
    bit               got;
    int               gap;
    in_valid_i <= 1'b1;
    in_data_i  <= item;
    do @(posedge clk_i); while (!in_ready_o);
    got = parse_char(item, r);
    if (got) results_due.push_back(typed ? typed_res : r);
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      burst_left = $urandom_range(0, 19);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 8);
      if (gap > 0) begin
        in_valid_i <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
  endtask

  task automatic wait_idle();
    in_valid_i <= 1'b0;
    while (results_due.size() != 0) @(posedge clk_i);
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic set_base(input logic [5:0] b);
    wait_idle();
    cfg_valid_i <= 1'b1;
    cfg_data_i  <= b;
    do @(posedge clk_i); while (!cfg_ready_o);
    cfg_valid_i <= 1'b0;
    base_reg = b;
  endtask

  initial begin : stimulus
    strint_pkg::in_t item;
    logic [7:0]      chs [$];
    logic [5:0]      phase_base [8];
    logic [5:0]      b;
    int              sent;
    int              k;
    int              radix;
    int              top;
    int              n_send;

    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (plan[i]) begin
      if (plan[i].first && plan[i].base != base_reg) set_base(plan[i].base);
      item.ch    = plan[i].ch;
      item.first = plan[i].first;
      offer_char(item, plan[i].typed, plan[i].res);
    end

    phase_base = '{strint_pkg::BASE_DEC, strint_pkg::BASE_HEX, strint_pkg::BASE_AUTO, 6'd36,
                   6'd2, strint_pkg::BASE_OCT, 6'd37, 6'd0};
    phase_base[6] = 6'($urandom_range(37, 63));
    phase_base[7] = 6'($urandom_range(0, 63));

    foreach (phase_base[p]) begin
      b = phase_base[p];
      set_base(b);
      if (p == 1) hold_off_req = 1'b1;
      sent = 0;
      while (sent < ITEMS_PER_PHASE) begin
        if ($urandom_range(0, 4) == 0) begin
          // noise: random bytes with random first marks
          repeat ($urandom_range(1, 6)) begin
            item.ch    = 8'($urandom_range(0, 255));
            item.first = 1'($urandom_range(0, 1));
            offer_char(item, 1'b0, NO_RES);
            sent++;
          end
        end else begin
          // well-formed number: spaces, sign, prefix, digits, then a random final byte
          chs.delete();
          repeat ($urandom_range(0, 3)) begin
            k = $urandom_range(8, 13);
            chs.push_back((k == 8) ? strint_pkg::CH_SPACE : 8'(k));
          end
          k = $urandom_range(0, 2);
          if (k == 1) chs.push_back(strint_pkg::CH_MINUS);
          else if (k == 2) chs.push_back(strint_pkg::CH_PLUS);
          radix = (b == strint_pkg::BASE_AUTO) ? 10 : int'(b);
          if (b == strint_pkg::BASE_AUTO || b == strint_pkg::BASE_HEX) begin
            k = $urandom_range(0, 2);
            if (k == 1) begin
              chs.push_back(strint_pkg::CH_ZERO);
              chs.push_back($urandom_range(0, 1) ? strint_pkg::CH_LOWER_X
                                                 : strint_pkg::CH_UPPER_X);
              radix = 16;
            end else if (k == 2 && b == strint_pkg::BASE_AUTO) begin
              chs.push_back(strint_pkg::CH_ZERO);
              radix = 8;
            end
          end
          top = (radix > 36) ? 35 : radix - 1;
          repeat (($urandom_range(0, 3) == 0) ? $urandom_range(12, 24)
                                              : $urandom_range(0, 8)) begin
            k = $urandom_range(0, top);
            if (k < 10) chs.push_back(strint_pkg::CH_ZERO + 8'(k));
            else chs.push_back(($urandom_range(0, 1) ? strint_pkg::UPPER_OFS
                                                     : strint_pkg::LOWER_OFS) + 8'(k));
          end
          chs.push_back(8'($urandom_range(0, 255)));
          // cut some strings short so the next first drops them
          n_send = ($urandom_range(0, 7) == 0) ? $urandom_range(1, chs.size()) : chs.size();
          for (int i = 0; i < n_send; i++) begin
            item.ch    = chs[i];
            item.first = (i == 0);
            offer_char(item, 1'b0, NO_RES);
            sent++;
          end
          repeat ($urandom_range(0, 2)) begin
            item.ch    = 8'($urandom_range(0, 255));
            item.first = 1'b0;
            offer_char(item, 1'b0, NO_RES);
          end
        end
      end
      // close any open string before the next base write
      item.ch    = CH_NUL;
      item.first = 1'b0;
      offer_char(item, 1'b0, NO_RES);
    end

    // Leading spaces, then a signed number
    set_base(strint_pkg::BASE_DEC);
    item.ch    = strint_pkg::CH_SPACE;
    item.first = 1'b1;
    offer_char(item, 1'b0, NO_RES);
    item.first = 1'b0;
    repeat (LEAD_SPACES) offer_char(item, 1'b0, NO_RES);
    chs.delete();
    chs.push_back(strint_pkg::CH_MINUS);
    chs.push_back("4");
    chs.push_back("2");
    chs.push_back(CH_NUL);
    foreach (chs[i]) begin
      item.ch = chs[i];
      offer_char(item, 1'b0, NO_RES);
    end

    wait_idle();
    if (mismatches == 0) $display("PASS string_to_integer_parser");
    else $display("FAIL string_to_integer_parser");
    $finish;
  end

  // Receiver: random ready patterns, free-running stretches, and one long hold-off
  initial begin : receiver
    logic [31:0] pat;
    int          mode;
    int          span;
    wait (rst_ni === 1'b1);
    @(posedge clk_i);
    forever begin
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        out_ready_i <= 1'b0;
        repeat (HOLD_OFF_CYCLES) @(posedge clk_i);
      end else begin
        mode = $urandom_range(0, 3);
        pat  = (mode == 0) ? '1 : (mode == 3) ? ($urandom | $urandom) : $urandom;
        span = $urandom_range(8, 32);
        for (int i = 0; i < span; i++) begin
          out_ready_i <= pat[i];
          @(posedge clk_i);
        end
      end
    end
  end

  always @(posedge clk_i) begin : check_results
    strint_pkg::out_t want;
    if (rst_ni && out_valid_o && out_ready_i) begin
      if (results_due.size() == 0) begin
        $error("unexpected result: value %0d consumed %0d", out_data_o.value,
               out_data_o.consumed);
        mismatches++;
      end else begin
        want = results_due.pop_front();
        if (out_data_o.value !== want.value) begin
          $error("value: expected %0d, got %0d", want.value, out_data_o.value);
          mismatches++;
        end
        if (out_data_o.consumed !== want.consumed) begin
          $error("consumed: expected %0d, got %0d", want.consumed, out_data_o.consumed);
          mismatches++;
        end
        if (out_data_o.digits_found !== want.digits_found) begin
          $error("digits_found: expected %0b, got %0b", want.digits_found,
                 out_data_o.digits_found);
          mismatches++;
        end
        if (out_data_o.overflow !== want.overflow) begin
          $error("overflow: expected %0b, got %0b", want.overflow, out_data_o.overflow);
          mismatches++;
        end
      end
    end
  end

  // Watchdog: count cycles without any transfer
  always @(posedge clk_i) begin
    if (!rst_ni || (in_valid_i && in_ready_o) || (out_valid_o && out_ready_i) ||
        (cfg_valid_i && cfg_ready_o)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
    if (idle_cycles >= STALL_LIMIT) begin
      $display("FAIL string_to_integer_parser");
      $finish;
    end
  end

endmodule
